FILE: design/idll_pkg.sv
// Shared codes, field types and widths for the indexed doubly linked list.
package idll_pkg;

	localparam int FUNC_W   = 3;
	localparam int POS_W    = 8;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;

	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [POS_W-1:0]    slot_byte_t;
	typedef logic [DATA_W-1:0]   data_word_t;

	localparam func_t FN_PUSH_FRONT = 3'd0;
	localparam func_t FN_PUSH_BACK  = 3'd1;
	localparam func_t FN_INS_AFTER  = 3'd2;
	localparam func_t FN_INS_BEFORE = 3'd3;
	localparam func_t FN_ERASE      = 3'd4;

	localparam status_t STS_OK     = 2'd0;
	localparam status_t STS_NOELEM = 2'd1;
	localparam status_t STS_FULL   = 2'd2;

endpackage

FILE: design/idll_if.sv
// Valid/ready channel interfaces for the request and response sides of the list.
interface idll_req_if import idll_pkg::*; ();
	logic       valid;
	logic       ready;
	func_t      func;
	slot_byte_t pos;
	data_word_t value;

	modport source (output valid, output func, output pos, output value, input ready);
	modport sink (input valid, input func, input pos, input value, output ready);
endinterface

interface idll_rsp_if import idll_pkg::*; ();
	logic       valid;
	logic       ready;
	status_t    status;
	slot_byte_t slot;
	slot_byte_t head;
	slot_byte_t tail;
	logic       empty_res;

	modport source (output valid, output status, output slot, output head, output tail,
		output empty_res, input ready);
	modport sink (input valid, input status, input slot, input head, input tail,
		input empty_res, output ready);
endinterface

FILE: design/idll_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module idll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/indexed_doubly_linked_list.sv
// Top level of the indexed doubly linked list with its free slot chain.
//
// Requests arrive on req (func, pos, value) and each one yields exactly one response
// on rsp (status, slot, head, tail, empty_res); a transaction completes when valid and
// ready are both high at a rising clock edge.
// An operation runs in steps: in the cycle a request is accepted the anchor's
// next link, previous link and live bit are read from their RAMs; in the following
// cycle the block decides, updates head, tail and the free chain and does the first
// link writes. The remaining neighbor link writes and the response load happen in the
// finish step, which also accepts the next request; since each link RAM has a single
// write port, a new request is taken only in the finish step of the one before. Write
// data of the finish step is forwarded to the reads of the request accepted beside it.
// While a response waits in the output register and the receiver holds ready low,
// the block can still accept one request while idle, but that operation then holds in
// its finish step and no further request is accepted.
// After reset the list is empty and slot 1 heads the free chain. No clearing pass
// is needed: a fill mark separates slots never taken, whose links and live bits are
// implied, from slots that have been written.
module indexed_doubly_linked_list import idll_pkg::*; #(
	parameter int CAPACITY    = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	idll_req_if.sink          req,
	idll_rsp_if.source        rsp
);

	localparam int IW = $clog2(CAPACITY);
	localparam int FW = IW + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
	localparam logic [IW-1:0] IDX_ZERO = '0;
	localparam logic [IW-1:0] IDX_ONE  = IW'(1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	function automatic slot_byte_t idx_byte(input logic [IW-1:0] i);
		logic [31:0] w;
		w = 32'(i);
		return w[POS_W-1:0];
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] fit_value(input data_word_t v);
		logic [63:0] w;
		w = 64'(v);
		return w[VALUE_WIDTH-1:0];
	endfunction

	logic [1:0] state_q;

	// List state.
	logic [IW-1:0] head_q, tail_q, free_q, free_nx_q;
	logic [FW-1:0] fresh_q;
	logic          empty_q;

	// Request captured at accept.
	func_t                  func_q;
	logic [IW-1:0]          pos_q;
	logic                   pos_ok_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   fwd_nx_hit_q, fwd_pv_hit_q;
	logic [IW-1:0]          fwd_nx_data_q, fwd_pv_data_q;

	// Finish step work.
	logic          take_s2;
	status_t       status_s2;
	logic [IW-1:0] slot_s2;
	logic          w2n_en_s2, w2p_en_s2;
	logic [IW-1:0] w2n_addr_s2, w2n_data_s2, w2p_addr_s2, w2p_data_s2;

	// Response register.
	logic       rsp_valid_q;
	status_t    rsp_status_q;
	slot_byte_t rsp_slot_q, rsp_head_q, rsp_tail_q;
	logic       rsp_empty_q;

	logic          acc, fin_go, in_exec;
	logic [31:0]   pos32;
	logic [IW-1:0] pos_idx_in;
	logic          pos_ok_in;

	// RAM ports.
	logic          next_we, next_re, prev_we, prev_re, node_we, node_re;
	logic [IW-1:0] next_waddr, next_wdata, next_raddr, next_rdata;
	logic [IW-1:0] prev_waddr, prev_wdata, prev_rdata;
	logic [IW-1:0] node_waddr;
	logic [VALUE_WIDTH:0] node_wdata, node_rdata;

	// Decision logic of the execute step.
	logic [IW-1:0] nb, pb, s;
	logic          live_eff, full, take, do_erase;
	status_t       x_status;
	logic [IW-1:0] x_slot, head_n, tail_n, free_n, free_nx_n;
	logic          empty_n;
	logic          w1n_en, w1p_en, w2n_en, w2p_en;
	logic [IW-1:0] w1n_addr, w1n_data, w1p_addr, w1p_data;
	logic [IW-1:0] w2n_addr, w2n_data, w2p_addr, w2p_data;
	logic [IW-1:0] free_nx_fill;

	assign in_exec    = (state_q == S_EXEC);
	assign fin_go     = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);
	assign req.ready  = (state_q == S_IDLE) || fin_go;
	assign acc        = req.valid && req.ready;
	assign pos32      = 32'(req.pos);
	assign pos_idx_in = pos32[IW-1:0];
	assign pos_ok_in  = (req.pos != '0) && (pos32 < 32'(CAPACITY));

	assign nb = fwd_nx_hit_q ? fwd_nx_data_q : next_rdata;
	assign pb = fwd_pv_hit_q ? fwd_pv_data_q : prev_rdata;
	assign s  = free_q;
	// Slots at or above the fill mark were never taken, so they cannot be live.
	assign live_eff = pos_ok_q && ({1'b0, pos_q} < fresh_q) && node_rdata[VALUE_WIDTH];
	assign full     = (free_q == IDX_ZERO);

	always_comb begin
		x_status  = STS_OK;
		x_slot    = IDX_ZERO;
		head_n    = head_q;
		tail_n    = tail_q;
		empty_n   = empty_q;
		free_n    = free_q;
		free_nx_n = free_nx_q;
		take      = 1'b0;
		do_erase  = 1'b0;
		w1n_en = 1'b0; w1n_addr = IDX_ZERO; w1n_data = IDX_ZERO;
		w1p_en = 1'b0; w1p_addr = IDX_ZERO; w1p_data = IDX_ZERO;
		w2n_en = 1'b0; w2n_addr = IDX_ZERO; w2n_data = IDX_ZERO;
		w2p_en = 1'b0; w2p_addr = IDX_ZERO; w2p_data = IDX_ZERO;
		case (func_q)
			FN_PUSH_FRONT, FN_PUSH_BACK: begin
				if (full) begin
					x_status = STS_FULL;
				end else begin
					take   = 1'b1;
					w1n_en = 1'b1; w1n_addr = s;
					w1p_en = 1'b1; w1p_addr = s;
					if (empty_q) begin
						head_n  = s;
						tail_n  = s;
						empty_n = 1'b0;
					end else if (func_q == FN_PUSH_FRONT) begin
						w1n_data = head_q;
						w2p_en = 1'b1; w2p_addr = head_q; w2p_data = s;
						head_n = s;
					end else begin
						w1p_data = tail_q;
						w2n_en = 1'b1; w2n_addr = tail_q; w2n_data = s;
						tail_n = s;
					end
				end
			end
			FN_INS_AFTER, FN_INS_BEFORE: begin
				if (!live_eff) begin
					x_status = STS_NOELEM;
				end else if (full) begin
					x_status = STS_FULL;
				end else begin
					take   = 1'b1;
					w1n_en = 1'b1; w1n_addr = s;
					w1p_en = 1'b1; w1p_addr = s;
					if (func_q == FN_INS_AFTER) begin
						w1n_data = nb;
						w1p_data = pos_q;
						w2n_en = 1'b1; w2n_addr = pos_q; w2n_data = s;
						if (pos_q == tail_q) begin
							tail_n = s;
						end else begin
							w2p_en = 1'b1; w2p_addr = nb; w2p_data = s;
						end
					end else begin
						w1n_data = pos_q;
						w1p_data = pb;
						w2p_en = 1'b1; w2p_addr = pos_q; w2p_data = s;
						if (pos_q == head_q) begin
							head_n = s;
						end else begin
							w2n_en = 1'b1; w2n_addr = pb; w2n_data = s;
						end
					end
				end
			end
			FN_ERASE: begin
				if (!live_eff) begin
					x_status = STS_NOELEM;
				end else begin
					do_erase  = 1'b1;
					x_slot    = pos_q;
					// The freed slot goes to the front of the free chain.
					w1n_en = 1'b1; w1n_addr = pos_q; w1n_data = free_q;
					w1p_en = 1'b1; w1p_addr = pos_q;
					free_n    = pos_q;
					free_nx_n = free_q;
					if (pos_q == head_q && pos_q == tail_q) begin
						head_n  = IDX_ZERO;
						tail_n  = IDX_ZERO;
						empty_n = 1'b1;
					end else if (pos_q == head_q) begin
						head_n = nb;
						w2p_en = 1'b1; w2p_addr = nb;
					end else if (pos_q == tail_q) begin
						tail_n = pb;
						w2n_en = 1'b1; w2n_addr = pb;
					end else begin
						w2n_en = 1'b1; w2n_addr = pb; w2n_data = nb;
						w2p_en = 1'b1; w2p_addr = nb; w2p_data = pb;
					end
				end
			end
			default: begin
			end
		endcase
		if (take) begin
			x_slot = s;
			free_n = free_nx_q;
		end
	end

	// Next link of the new free head; a never-taken slot links to its successor, the last slot to zero.
	always_comb begin
		if ({1'b0, free_q} >= fresh_q) begin
			free_nx_fill = (free_q == LAST_IDX) ? IDX_ZERO : free_q + IDX_ONE;
		end else begin
			free_nx_fill = next_rdata;
		end
	end

	// RAM port control.
	assign next_re    = acc || in_exec;
	assign next_raddr = acc ? pos_idx_in : free_nx_q;
	assign next_we    = (in_exec && w1n_en) || (fin_go && w2n_en_s2);
	assign next_waddr = in_exec ? w1n_addr : w2n_addr_s2;
	assign next_wdata = in_exec ? w1n_data : w2n_data_s2;

	assign prev_re    = acc;
	assign prev_we    = (in_exec && w1p_en) || (fin_go && w2p_en_s2);
	assign prev_waddr = in_exec ? w1p_addr : w2p_addr_s2;
	assign prev_wdata = in_exec ? w1p_data : w2p_data_s2;

	assign node_re    = acc;
	assign node_we    = in_exec && (take || do_erase);
	assign node_waddr = take ? s : pos_q;
	assign node_wdata = {take, value_q};

	idll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.re    (next_re),
		.raddr (next_raddr),
		.rdata (next_rdata)
	);

	idll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.re    (prev_re),
		.raddr (pos_idx_in),
		.rdata (prev_rdata)
	);

	idll_ram #(.WIDTH(VALUE_WIDTH + 1), .DEPTH(CAPACITY)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (node_re),
		.raddr (pos_idx_in),
		.rdata (node_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= IDX_ZERO;
			tail_q      <= IDX_ZERO;
			free_q      <= IDX_ONE;
			free_nx_q   <= IW'(2);
			fresh_q     <= FW'(1);
			empty_q     <= 1'b1;
			rsp_valid_q <= 1'b0;
			take_s2     <= 1'b0;
			w2n_en_s2   <= 1'b0;
			w2p_en_s2   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q   <= S_FIN;
					head_q    <= head_n;
					tail_q    <= tail_n;
					empty_q   <= empty_n;
					free_q    <= free_n;
					free_nx_q <= free_nx_n;
					take_s2   <= take;
					w2n_en_s2 <= w2n_en;
					w2p_en_s2 <= w2p_en;
					if (take && ({1'b0, s} == fresh_q)) begin
						fresh_q <= fresh_q + FW'(1);
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= acc ? S_EXEC : S_IDLE;
						if (take_s2) begin
							free_nx_q <= free_nx_fill;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			func_q        <= req.func;
			pos_q         <= pos_idx_in;
			pos_ok_q      <= pos_ok_in;
			value_q       <= fit_value(req.value);
			fwd_nx_hit_q  <= fin_go && w2n_en_s2 && (w2n_addr_s2 == pos_idx_in);
			fwd_nx_data_q <= w2n_data_s2;
			fwd_pv_hit_q  <= fin_go && w2p_en_s2 && (w2p_addr_s2 == pos_idx_in);
			fwd_pv_data_q <= w2p_data_s2;
		end
		if (in_exec) begin
			status_s2   <= x_status;
			slot_s2     <= x_slot;
			w2n_addr_s2 <= w2n_addr;
			w2n_data_s2 <= w2n_data;
			w2p_addr_s2 <= w2p_addr;
			w2p_data_s2 <= w2p_data;
		end
		if (fin_go) begin
			rsp_status_q <= status_s2;
			rsp_slot_q   <= idx_byte(slot_s2);
			rsp_head_q   <= idx_byte(head_q);
			rsp_tail_q   <= idx_byte(tail_q);
			rsp_empty_q  <= empty_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.slot      = rsp_slot_q;
	assign rsp.head      = rsp_head_q;
	assign rsp.tail      = rsp_tail_q;
	assign rsp.empty_res = rsp_empty_q;

endmodule
